// File: rtl/mcpdf_pkg.sv
// ----------------------------------------------------------------------------
// mcpdf_pkg
// Shared types and constants for the MIDI cross-port duplicate filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mcpdf_pkg;

  // Hash: channel * HASH_MUL + data_first, before reduction to a slot.
  localparam int HASH_MUL = 17;
  localparam int HASH_W   = 10;
  localparam int HASH_MAX = 31 * HASH_MUL + 127;

  // Source ids at or above this are never valid.
  localparam int MAX_SOURCES = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW    = 2'd0,
    CFG_SRC_COUNT = 2'd1,
    CFG_DUAL      = 2'd2,
    CFG_DEDUP_EN  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] dedup_window_us;
    logic [3:0]  source_count;
    logic [7:0]  dual_mask;
    logic [7:0]  dedup_enable_mask;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  source_port;
    logic [2:0]  message_type;
    logic [4:0]  channel;
    logic [6:0]  data_first;
    logic [6:0]  data_second;
    logic [47:0] time_us;
  } in_word_t;

  typedef struct packed {
    logic        is_duplicate;
    logic [31:0] duplicate_total;
  } out_word_t;

  // One table slot: last event seen for the slot.
  typedef struct packed {
    logic        valid;
    logic [2:0]  source;
    logic [2:0]  message_type;
    logic [4:0]  channel;
    logic [6:0]  data_first;
    logic [6:0]  data_second;
    logic [47:0] time_us;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/midi_cross_port_duplicate_filter.sv
// ----------------------------------------------------------------------------
// midi_cross_port_duplicate_filter
// Flags MIDI events that are cross-port copies of the previous event held in
// a hashed slot table, and keeps a wrapping count of flagged words.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one event word per valid/ready handshake.
//   out_*  : one result word per event, in order: is_duplicate and the
//            running suppressed total including this word.
//   cfg_*  : plain write port; write only while the filter is idle.
// Path: an accepted word sits in the lookup stage, then moves on to the
//   output register once that register is free or being read.
// Throughput: one word per cycle while output is read. A word reads its
//   slot at acceptance, writes it back as it leaves the lookup stage; a
//   back-to-back hit on the same slot is served from a forwarding register.
// Reset: control and config clear, then the slot memory is swept invalid,
//   one slot a cycle, with in_ready low until the sweep ends. Config writes
//   are taken during the sweep.
// Stall: a full output register holds its word; the lookup stage then holds
//   too and in_ready drops only once that stage is also occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_cross_port_duplicate_filter #(
  parameter int TABLE_SLOTS = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  mcpdf_pkg::in_word_t                      in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output mcpdf_pkg::out_word_t                     out_data,
  input  wire logic                                cfg_we,
  input  wire logic [mcpdf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mcpdf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  // quotient bits of the hash reduction
  localparam int QB = $clog2(mcpdf_pkg::HASH_MAX / TABLE_SLOTS + 1);
  localparam int HW = mcpdf_pkg::HASH_W;

  // Config registers
  mcpdf_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (mcpdf_pkg::cfg_idx_t'(cfg_index))
        mcpdf_pkg::CFG_WINDOW:    cfg_r.dedup_window_us   <= cfg_wdata;
        mcpdf_pkg::CFG_SRC_COUNT: cfg_r.source_count      <= cfg_wdata[3:0];
        mcpdf_pkg::CFG_DUAL:      cfg_r.dual_mask         <= cfg_wdata[7:0];
        mcpdf_pkg::CFG_DEDUP_EN:  cfg_r.dedup_enable_mask <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Slot hash: (channel * 17 + data_first) mod TABLE_SLOTS, by restoring
  // subtraction of shifted slot counts.
  logic [HW-1:0] hash_rem;
  logic [AW-1:0] in_slot;

  always_comb begin
    hash_rem = HW'(in_data.channel) * HW'(mcpdf_pkg::HASH_MUL)
             + HW'(in_data.data_first);
    for (int k = QB - 1; k >= 0; k--) begin
      if (32'(hash_rem) >= 32'(TABLE_SLOTS << k)) begin
        hash_rem = hash_rem - HW'(TABLE_SLOTS << k);
      end
    end
    in_slot = AW'(hash_rem);
  end

  // Lookup stage (slot read data arrives here)
  logic                 b_valid_r;
  mcpdf_pkg::in_word_t  b_word_r;
  logic [AW-1:0]        b_slot_r;
  logic                 fwd_hit_r;
  mcpdf_pkg::entry_t    fwd_entry_r;

  logic                 tbl_busy;
  logic                 in_acc;
  logic                 b_adv;
  mcpdf_pkg::entry_t    rd_entry;
  mcpdf_pkg::entry_t    stored;
  mcpdf_pkg::entry_t    new_entry;
  logic                 dup;

  // Output register and counter
  logic                 out_valid_r;
  mcpdf_pkg::out_word_t out_word_r;
  mcpdf_pkg::out_word_t out_word_nxt;
  logic [31:0]          count_r;
  logic [31:0]          count_nxt;

  assign b_adv    = b_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !tbl_busy && (!b_valid_r || b_adv);
  assign in_acc   = in_valid && in_ready;

  // The word in the lookup stage writes its slot as it leaves; a word read
  // at that same edge missed the write and takes the forwarded copy.
  assign stored = fwd_hit_r ? fwd_entry_r : rd_entry;

  always_comb begin
    new_entry.valid        = 1'b1;
    new_entry.source       = b_word_r.source_port;
    new_entry.message_type = b_word_r.message_type;
    new_entry.channel      = b_word_r.channel;
    new_entry.data_first   = b_word_r.data_first;
    new_entry.data_second  = b_word_r.data_second;
    new_entry.time_us      = b_word_r.time_us;
  end

  mcpdf_table #(
    .DEPTH (TABLE_SLOTS),
    .AW    (AW)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (in_slot),
    .rd_entry (rd_entry),
    .wr_en    (b_adv),
    .wr_addr  (b_slot_r),
    .wr_entry (new_entry),
    .busy     (tbl_busy)
  );

  mcpdf_match u_match (
    .ev     (b_word_r),
    .stored (stored),
    .cfg    (cfg_r),
    .dup    (dup)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (in_acc) begin
        b_valid_r <= 1'b1;
        fwd_hit_r <= b_adv && (b_slot_r == in_slot);
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_word_r    <= in_data;
      b_slot_r    <= in_slot;
      fwd_entry_r <= new_entry;
    end
  end

  always_comb begin
    count_nxt                    = count_r + 32'(dup);
    out_word_nxt.is_duplicate    = dup;
    out_word_nxt.duplicate_total = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (b_adv) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

`default_nettype wire

// File: rtl/mcpdf_table.sv
// ----------------------------------------------------------------------------
// mcpdf_table
// Direct-mapped slot memory, one read and one write port, registered read.
// Sweeps every slot to invalid after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpdf_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output mcpdf_pkg::entry_t      rd_entry,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  mcpdf_pkg::entry_t      wr_entry,
  output logic                   busy
);

  mcpdf_pkg::entry_t mem [DEPTH];
  mcpdf_pkg::entry_t rd_entry_r;
  logic [AW-1:0]     clr_addr_r;
  logic              clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // read-before-write on a clash; caller forwards
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= mem[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;
  assign busy     = clr_busy_r;

endmodule

`default_nettype wire

// File: rtl/mcpdf_match.sv
// ----------------------------------------------------------------------------
// mcpdf_match
// Duplicate decision: stored slot against the arriving event.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpdf_match (
  input  mcpdf_pkg::in_word_t ev,
  input  mcpdf_pkg::entry_t   stored,
  input  mcpdf_pkg::cfg_t     cfg,
  output logic                dup
);

  logic        same;
  logic [48:0] gap;
  logic        recent;
  logic        src_ok_new;
  logic        src_ok_old;
  logic        masks_ok;

  always_comb begin
    same = stored.valid
        && stored.message_type == ev.message_type
        && stored.channel      == ev.channel
        && stored.data_first   == ev.data_first
        && stored.data_second  == ev.data_second;

    // borrow out of bit 48 means time went backwards
    gap    = {1'b0, ev.time_us} - {1'b0, stored.time_us};
    recent = !gap[48] && (gap[47:0] <= {16'd0, cfg.dedup_window_us});

    src_ok_new = ({1'b0, ev.source_port} < cfg.source_count)
              && (7'(ev.source_port) < 7'(mcpdf_pkg::MAX_SOURCES));
    src_ok_old = ({1'b0, stored.source} < cfg.source_count)
              && (7'(stored.source) < 7'(mcpdf_pkg::MAX_SOURCES));

    masks_ok = cfg.dedup_enable_mask[ev.source_port]
            && cfg.dual_mask[ev.source_port]
            && cfg.dual_mask[stored.source];

    dup = same && recent && src_ok_new && src_ok_old
       && (stored.source != ev.source_port) && masks_ok;
  end

endmodule

`default_nettype wire

// File: rtl/mcpdf_checker.sv
// ----------------------------------------------------------------------------
// mcpdf_checker
// Port-level checks for the duplicate filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpdf_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input mcpdf_pkg::out_word_t      out_data
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // nothing comes out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  // table sweep keeps input closed in the first cycle after reset
  a_sweep_closed: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_ready)
    else $error("input open before slot sweep");

  // back-to-back words: total steps by the flag
  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && out_ready) && out_valid |->
      out_data.duplicate_total ==
        $past(out_data.duplicate_total) + 32'(out_data.is_duplicate))
    else $error("suppressed total out of step");

endmodule

bind midi_cross_port_duplicate_filter mcpdf_checker u_mcpdf_checker (.*);

`default_nettype wire

// File: test/midi_cross_port_duplicate_filter_tb.sv
// ----------------------------------------------------------------------------
// midi_cross_port_duplicate_filter_tb
// Self-checking bench for the cross-port duplicate filter. Event words are
// pushed through the valid/ready input, and every result word is checked
// against a bench-side model of the slot table. A short directed table comes
// first, then several randomised phases under different register settings,
// with idle and stall patterns on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_cross_port_duplicate_filter_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = 64;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;   // length of the long output hold-off
  localparam int SETTLE      = 4;     // pipeline depth plus margin

  // One row of the directed table. Where known is set, the result word is
  // typed in; otherwise the bench model supplies it.
  typedef struct {
    mcpdf_pkg::in_word_t  word;
    bit                   known;
    mcpdf_pkg::out_word_t result;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  mcpdf_pkg::in_word_t  in_data;
  logic                 out_valid;
  logic                 out_ready;
  mcpdf_pkg::out_word_t out_data;
  logic                 cfg_we;
  logic [mcpdf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mcpdf_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // Bench copy of the register file.
  logic [31:0] cfg_window;
  logic [3:0]  cfg_src_count;
  logic [7:0]  cfg_dual;
  logic [7:0]  cfg_dedup_en;

  // Bench copy of the slot table and the suppressed count.
  logic [21:0] slot_body  [TABLE_SLOTS];
  logic [2:0]  slot_src   [TABLE_SLOTS];
  logic [47:0] slot_stamp [TABLE_SLOTS];
  bit          slot_live  [TABLE_SLOTS];
  logic [31:0] dup_total;

  mcpdf_pkg::out_word_t pending_verdicts[$];
  mcpdf_pkg::out_word_t want;
  int                   mismatch_count;
  int                   cycle_count;

  // Idle/stall odds in percent, and the hold-off request count.
  int send_idle_pct;
  int recv_stall_pct;
  int hold_reqs;
  int hold_done;

  // Recent events, reused to build cross-port copies.
  mcpdf_pkg::in_word_t event_pool [8];
  int                  pool_fill;
  int                  pool_wr;
  logic [47:0]         now_us;

  // Directed table.
  //   Copy within the window: flagged. Window exceeded by one, same source,
  //   time going backwards, arriving source invalid, stored source invalid,
  //   out-of-range channels, field extremes and a hash collision follow.
  //   Register setting: window 100, six sources, all dual, all enabled.
  dir_row_t directed_rows [16] = '{
    '{'{3'd0, 3'd1, 5'd1, 7'd60, 7'd100, 48'd1000}, 1'b1, '{1'b0, 32'd0}},
    '{'{3'd1, 3'd1, 5'd1, 7'd60, 7'd100, 48'd1050}, 1'b1, '{1'b1, 32'd1}},
    '{'{3'd2, 3'd1, 5'd1, 7'd60, 7'd100, 48'd1150}, 1'b1, '{1'b1, 32'd2}},
    '{'{3'd3, 3'd1, 5'd1, 7'd60, 7'd100, 48'd1251}, 1'b0, '{1'b0, 32'd0}},
    '{'{3'd3, 3'd1, 5'd1, 7'd60, 7'd100, 48'd1260}, 1'b0, '{1'b0, 32'd0}},
    '{'{3'd4, 3'd1, 5'd1, 7'd60, 7'd100, 48'd1200}, 1'b0, '{1'b0, 32'd0}},
    '{'{3'd6, 3'd1, 5'd1, 7'd60, 7'd100, 48'd1210}, 1'b0, '{1'b0, 32'd0}},
    '{'{3'd0, 3'd1, 5'd1, 7'd60, 7'd100, 48'd1220}, 1'b0, '{1'b0, 32'd0}},
    '{'{3'd0, 3'd0, 5'd0, 7'd0, 7'd0, 48'd0}, 1'b1, '{1'b0, 32'd2}},
    '{'{3'd1, 3'd0, 5'd0, 7'd0, 7'd0, 48'd0}, 1'b1, '{1'b1, 32'd3}},
    '{'{3'd7, 3'd7, 5'd31, 7'd127, 7'd127, 48'hFFFF_FFFF_FFFF}, 1'b1, '{1'b0, 32'd3}},
    '{'{3'd5, 3'd7, 5'd31, 7'd127, 7'd127, 48'hFFFF_FFFF_FFFF}, 1'b0, '{1'b0, 32'd0}},
    '{'{3'd2, 3'd7, 5'd31, 7'd127, 7'd126, 48'hFFFF_FFFF_FFFF}, 1'b0, '{1'b0, 32'd0}},
    '{'{3'd2, 3'd2, 5'd2, 7'd43, 7'd100, 48'd1300}, 1'b0, '{1'b0, 32'd0}},
    '{'{3'd1, 3'd1, 5'd1, 7'd60, 7'd100, 48'd1300}, 1'b0, '{1'b0, 32'd0}},
    '{'{3'd5, 3'd1, 5'd1, 7'd60, 7'd100, 48'd1310}, 1'b0, '{1'b0, 32'd0}}
  };

  midi_cross_port_duplicate_filter #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bench model of the filter
  // --------------------------------------------------------------------------

  function automatic bit source_live(logic [2:0] s);
    return (4'(s) < cfg_src_count) && (int'(s) < mcpdf_pkg::MAX_SOURCES);
  endfunction

  // Looks the event up in the slot table, decides whether it is a copy,
  // then overwrites the slot and bumps the total on a hit.
  function automatic mcpdf_pkg::out_word_t filter_event(mcpdf_pkg::in_word_t ev);
    int unsigned          slot;
    logic [21:0]          body;
    logic [2:0]           old_src;
    logic [47:0]          gap;
    bit                   hit;
    mcpdf_pkg::out_word_t res;
    slot    = (int'(ev.channel) * mcpdf_pkg::HASH_MUL + int'(ev.data_first))
              % TABLE_SLOTS;
    body    = {ev.message_type, ev.channel, ev.data_first, ev.data_second};
    old_src = slot_src[slot];
    gap     = ev.time_us - slot_stamp[slot];
    hit = slot_live[slot] && (slot_body[slot] == body)
          && (ev.time_us >= slot_stamp[slot]) && (gap <= {16'd0, cfg_window})
          && source_live(old_src) && source_live(ev.source_port)
          && (old_src != ev.source_port)
          && cfg_dedup_en[ev.source_port] && cfg_dual[ev.source_port]
          && cfg_dual[old_src];
    slot_body[slot]  = body;
    slot_src[slot]   = ev.source_port;
    slot_stamp[slot] = ev.time_us;
    slot_live[slot]  = 1'b1;
    if (hit) dup_total = dup_total + 32'd1;
    res.is_duplicate    = hit;
    res.duplicate_total = dup_total;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Random event source
  // --------------------------------------------------------------------------

  // Mostly copies of recent events from random ports, timed around the
  // window edge; the rest fresh events and raw noise.
  function automatic mcpdf_pkg::in_word_t next_event();
    mcpdf_pkg::in_word_t ev;
    mcpdf_pkg::in_word_t base;
    logic [47:0]         step;
    int                  pick;
    pick = $urandom_range(0, 99);
    if (pick < 55 && pool_fill > 0) begin
      base = event_pool[$urandom_range(0, pool_fill - 1)];
      ev = base;
      ev.source_port = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 6))
        0:       step = '0;
        1:       step = {16'd0, cfg_window};
        2:       step = {16'd0, cfg_window} + 48'd1;
        3, 4, 5: step = 48'($urandom) % ({16'd0, cfg_window} + 48'd1);
        default: step = 48'd0 - 48'($urandom_range(1, 1000));   // backwards
      endcase
      ev.time_us = base.time_us + step;
      // now and then a near miss: second data byte differs
      if ($urandom_range(0, 9) == 0) ev.data_second = 7'($urandom);
    end else if (pick < 85) begin
      now_us = now_us + 48'($urandom_range(0, 40));
      ev.source_port  = 3'($urandom_range(0, 7));
      ev.message_type = 3'($urandom_range(0, 7));
      ev.channel      = 5'($urandom_range(1, 16));
      ev.data_first   = 7'($urandom);
      ev.data_second  = 7'($urandom);
      ev.time_us      = now_us;
    end else begin
      ev = $bits(mcpdf_pkg::in_word_t)'({$urandom, $urandom, $urandom});
    end
    event_pool[pool_wr] = ev;
    pool_wr = (pool_wr + 1) % 8;
    if (pool_fill < 8) pool_fill++;
    return ev;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Offers one word and waits for it to be taken; in_valid stays high on
  // return so a following word can go straight out.
  task automatic send_word(mcpdf_pkg::in_word_t w, bit known,
                           mcpdf_pkg::out_word_t typed);
    mcpdf_pkg::out_word_t calc;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    calc = filter_event(w);
    pending_verdicts.push_back(known ? typed : calc);
  endtask

  task automatic write_reg(mcpdf_pkg::cfg_idx_t idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      mcpdf_pkg::CFG_WINDOW:    cfg_window    = value;
      mcpdf_pkg::CFG_SRC_COUNT: cfg_src_count = value[3:0];
      mcpdf_pkg::CFG_DUAL:      cfg_dual      = value[7:0];
      mcpdf_pkg::CFG_DEDUP_EN:  cfg_dedup_en  = value[7:0];
      default: ;
    endcase
  endtask

  // Unused upper bits of the narrow registers carry junk.
  task automatic set_filter(logic [31:0] window, logic [3:0] count,
                            logic [7:0] dual, logic [7:0] dedup_en);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(mcpdf_pkg::CFG_WINDOW, window);
    write_reg(mcpdf_pkg::CFG_SRC_COUNT, {junk[31:4], count});
    write_reg(mcpdf_pkg::CFG_DUAL, {junk[31:8], dual});
    write_reg(mcpdf_pkg::CFG_DEDUP_EN, {junk[31:8], dedup_en});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every word sent has come back, then lets the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------

  initial begin
    out_ready = 1'b0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_reqs) begin
        hold_done = hold_reqs;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: in order, field by field
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing outstanding", out_data));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data.is_duplicate !== want.is_duplicate)
          report_mismatch($sformatf("is_duplicate %b, want %b",
                                    out_data.is_duplicate, want.is_duplicate));
        if (out_data.duplicate_total !== want.duplicate_total)
          report_mismatch($sformatf("duplicate_total %0d, want %0d",
                                    out_data.duplicate_total, want.duplicate_total));
      end
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** midi_cross_port_duplicate_filter: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    int                   phase;
    int                   n_words;
    mcpdf_pkg::out_word_t none;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_index      = mcpdf_pkg::CFG_WINDOW;
    cfg_wdata      = '0;
    cycle_count    = 0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_reqs      = 0;
    pool_fill      = 0;
    pool_wr        = 0;
    now_us         = '0;
    none           = '0;
    // model state after reset: table empty, registers and total zero
    cfg_window    = '0;
    cfg_src_count = '0;
    cfg_dual      = '0;
    cfg_dedup_en  = '0;
    dup_total     = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      slot_body[i]  = '0;
      slot_src[i]   = '0;
      slot_stamp[i] = '0;
      slot_live[i]  = 1'b0;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part; the table sweep after reset holds in_ready low, so the
    // first word simply waits for it.
    set_filter(32'd100, 4'd6, 8'hFF, 8'hFF);
    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].result);
    drain();

    // Random phases, each under its own register setting and idle pattern.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin   // dense copies, no idling
          set_filter(32'($urandom_range(0, 300)), 4'd8, 8'hFF, 8'hFF);
          send_idle_pct = 0;  recv_stall_pct = 0;  n_words = 340;
        end
        1: begin   // zero window, sender mostly idle
          set_filter(32'd0, 4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom));
          send_idle_pct = 70; recv_stall_pct = 0;  n_words = 280;
        end
        2: begin   // widest window, source count above eight
          set_filter(32'hFFFF_FFFF, 4'd15, 8'($urandom), 8'hFF);
          send_idle_pct = 0;  recv_stall_pct = 70; n_words = 280;
        end
        3: begin   // everything random, both sides idling
          set_filter(32'($urandom_range(0, 5000)), 4'($urandom_range(0, 15)),
                     8'($urandom), 8'($urandom));
          send_idle_pct = 37; recv_stall_pct = 37; n_words = 280;
        end
        4: begin   // output held off while the sender keeps offering
          set_filter(32'd1000, 4'd8, 8'hFF, 8'($urandom));
          send_idle_pct = 0;  recv_stall_pct = 0;  n_words = 150;
          hold_reqs++;
        end
        default: begin   // nothing valid: no source, no dual, no enable
          set_filter(32'($urandom), 4'd0, 8'h00, 8'h00);
          send_idle_pct = 37; recv_stall_pct = 37; n_words = 100;
        end
      endcase
      repeat (n_words) send_word(next_event(), 1'b0, none);
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** midi_cross_port_duplicate_filter: PASSED **");
    end else begin
      $display("** midi_cross_port_duplicate_filter: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
